@@ hw/rtl/lmms_pkg.sv @@
// ----------------------------------------------------------------------------
// lmms_pkg
// Shared types, codes and the meter pattern table for the LED matrix scanner.
// ----------------------------------------------------------------------------
package lmms_pkg;

    localparam int DEF_NUM_COLUMNS = 8;

    localparam int ACT_W  = 2;
    localparam int CH_W   = 4;
    localparam int RAW_W  = 6;
    localparam int LVL_W  = 3;
    localparam int COL_W  = 3;
    localparam int WORD_W = 16;
    localparam int ROW_W  = 7;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    // action codes
    localparam logic [ACT_W-1:0] ACT_SCAN   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RAW    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LEVEL  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_SWITCH = 2'd3;

    // meter level codes
    localparam logic [LVL_W-1:0] LVL_OFF    = 3'd0;
    localparam logic [LVL_W-1:0] LVL_0DB    = 3'd1;
    localparam logic [LVL_W-1:0] LVL_M3DB   = 3'd2;
    localparam logic [LVL_W-1:0] LVL_M6DB   = 3'd3;
    localparam logic [LVL_W-1:0] LVL_M12DB  = 3'd4;
    localparam logic [LVL_W-1:0] LVL_M18DB  = 3'd5;
    localparam logic [LVL_W-1:0] LVL_M42DB  = 3'd6;
    localparam logic [LVL_W-1:0] LVL_IGNORE = 3'd7;

    typedef struct packed {
        logic [1:0]       pad;
        logic             switch_on;
        logic [LVL_W-1:0] meter_level;
        logic [RAW_W-1:0] raw_bits;
        logic [CH_W-1:0]  channel;
    } t_in_data;

    typedef struct packed {
        logic [4:0]        pad;
        logic [COL_W-1:0]  column_index;
        logic [WORD_W-1:0] port_word;
    } t_out_data;

    // lane write request into the pattern store
    typedef struct packed {
        logic             mtr_we;
        logic             sw_we;
        logic [COL_W-1:0] idx;
        logic [RAW_W-1:0] mtr_data;
        logic             sw_data;
    } t_wr_req;

    // meter row bits 6..1 for each level, as a 6-bit lane value
    function automatic logic [RAW_W-1:0] meter_pattern(input logic [LVL_W-1:0] lvl);
        logic [RAW_W-1:0] pat;
        pat = '0;
        case (lvl)
            LVL_OFF:   pat = 6'h00;
            LVL_0DB:   pat = 6'h3F;
            LVL_M3DB:  pat = 6'h1F;
            LVL_M6DB:  pat = 6'h0F;
            LVL_M12DB: pat = 6'h07;
            LVL_M18DB: pat = 6'h03;
            LVL_M42DB: pat = 6'h01;
            default:   pat = 6'h00;
        endcase
        return pat;
    endfunction

endpackage

@@ hw/rtl/lmms_decode.sv @@
// ----------------------------------------------------------------------------
// lmms_decode
// Turns an accepted set action into a lane write request for the store.
// ----------------------------------------------------------------------------
module lmms_decode #(
    parameter int NUM_COLUMNS = lmms_pkg::DEF_NUM_COLUMNS
) (
    input  logic                        i_en,
    input  logic [lmms_pkg::ACT_W-1:0]  i_action,
    input  logic [lmms_pkg::CH_W-1:0]   i_channel,
    input  logic [lmms_pkg::RAW_W-1:0]  i_raw_bits,
    input  logic [lmms_pkg::LVL_W-1:0]  i_meter_level,
    input  logic                        i_switch_on,
    output lmms_pkg::t_wr_req           o_wr
);
    import lmms_pkg::*;

    logic            ch_ok;
    logic [CH_W-1:0] ch_m1;

    always_comb begin
        ch_ok = (i_channel != '0) && (i_channel <= CH_W'(NUM_COLUMNS));
        ch_m1 = i_channel - CH_W'(1);

        o_wr          = '0;
        o_wr.idx      = ch_m1[COL_W-1:0];
        o_wr.mtr_data = i_raw_bits;
        o_wr.sw_data  = i_switch_on;

        unique case (i_action)
            ACT_SCAN: begin
                o_wr.mtr_we = 1'b0;
            end
            ACT_RAW: begin
                o_wr.mtr_we = i_en && ch_ok;
            end
            ACT_LEVEL: begin
                o_wr.mtr_we   = i_en && ch_ok && (i_meter_level != LVL_IGNORE);
                o_wr.mtr_data = meter_pattern(i_meter_level);
            end
            ACT_SWITCH: begin
                o_wr.sw_we = i_en && ch_ok;
            end
        endcase
    end

endmodule

@@ hw/rtl/lmms_store.sv @@
// ----------------------------------------------------------------------------
// lmms_store
// Row pattern store: a meter lane memory and a switch lane memory, each with
// per-entry valid bits so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
module lmms_store #(
    parameter int NUM_COLUMNS = lmms_pkg::DEF_NUM_COLUMNS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lmms_pkg::t_wr_req           i_wr,
    input  logic                        i_rd_en,
    input  logic [lmms_pkg::COL_W-1:0]  i_rd_idx,
    output logic [lmms_pkg::ROW_W-1:0]  o_rd_pat
);
    import lmms_pkg::*;

    localparam int IDX_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;

    logic [RAW_W-1:0]       mem_mtr [NUM_COLUMNS];
    logic                   mem_sw  [NUM_COLUMNS];
    logic [NUM_COLUMNS-1:0] r_mtr_vld;
    logic [NUM_COLUMNS-1:0] r_sw_vld;

    logic [RAW_W-1:0] r_mtr_q;
    logic             r_sw_q;
    logic             r_mtr_q_vld;
    logic             r_sw_q_vld;

    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;

    assign wr_idx = i_wr.idx[IDX_W-1:0];
    assign rd_idx = i_rd_idx[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_wr.mtr_we) begin
            mem_mtr[wr_idx] <= i_wr.mtr_data;
        end
        if (i_wr.sw_we) begin
            mem_sw[wr_idx] <= i_wr.sw_data;
        end
        if (i_rd_en) begin
            r_mtr_q <= mem_mtr[rd_idx];
            r_sw_q  <= mem_sw[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mtr_vld   <= '0;
            r_sw_vld    <= '0;
            r_mtr_q_vld <= 1'b0;
            r_sw_q_vld  <= 1'b0;
        end else begin
            if (i_wr.mtr_we) begin
                r_mtr_vld[wr_idx] <= 1'b1;
            end
            if (i_wr.sw_we) begin
                r_sw_vld[wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_mtr_q_vld <= r_mtr_vld[rd_idx];
                r_sw_q_vld  <= r_sw_vld[rd_idx];
            end
        end
    end

    assign o_rd_pat = {(r_mtr_q_vld ? r_mtr_q : RAW_W'(0)), (r_sw_q_vld & r_sw_q)};

endmodule

@@ hw/rtl/led_matrix_meter_scanner.sv @@
// ----------------------------------------------------------------------------
// led_matrix_meter_scanner
// Multiplexed LED matrix driver with a level meter and a switch LED per column.
// ----------------------------------------------------------------------------
// pipeline: a scan tick's port word passes the read stage (synchronous pattern
//   memory read) and then loads the output register once that register is free
// throughput: one item per cycle while results are taken; set items give none
// reset clears the scan column and the store valid bits at once, so every
// column reads as dark; memory contents themselves are not swept
module led_matrix_meter_scanner #(
    parameter int NUM_COLUMNS = lmms_pkg::DEF_NUM_COLUMNS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // channel[3:0], raw_bits[9:4], meter_level[12:10], switch_on[13], zero pad
    input  logic [lmms_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // action[1:0]
    input  logic [lmms_pkg::ACT_W-1:0]        i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // port_word[15:0], column_index[18:16], zero pad
    output logic [lmms_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);
    import lmms_pkg::*;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(NUM_COLUMNS - 1);

    t_in_data  in_data;
    t_wr_req   wr_req;
    t_out_data out_word;

    logic [COL_W-1:0] r_col, n_col;
    logic             r_s1_vld, n_s1_vld;
    logic [COL_W-1:0] r_s1_col, n_s1_col;
    logic             r_out_vld, n_out_vld;
    t_out_data        r_out_data, n_out_data;

    logic             s1_adv;
    logic             in_rdy;
    logic             in_acc;
    logic             scan_acc;
    logic [ROW_W-1:0] rd_pat;
    logic [7:0]       col_sel;

    assign in_data = t_in_data'(i_s_axis_tdata);

    lmms_decode #(
        .NUM_COLUMNS (NUM_COLUMNS)
    ) u_decode (
        .i_en          (in_acc),
        .i_action      (i_s_axis_tuser),
        .i_channel     (in_data.channel),
        .i_raw_bits    (in_data.raw_bits),
        .i_meter_level (in_data.meter_level),
        .i_switch_on   (in_data.switch_on),
        .o_wr          (wr_req)
    );

    lmms_store #(
        .NUM_COLUMNS (NUM_COLUMNS)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (wr_req),
        .i_rd_en  (scan_acc),
        .i_rd_idx (r_col),
        .o_rd_pat (rd_pat)
    );

    always_comb begin
        s1_adv   = !r_out_vld || i_m_axis_tready;
        in_rdy   = !r_s1_vld || s1_adv;
        in_acc   = i_s_axis_tvalid && in_rdy;
        scan_acc = in_acc && (i_s_axis_tuser == ACT_SCAN);

        col_sel                = ~(8'd1 << r_s1_col);
        out_word.pad           = '0;
        out_word.column_index  = r_s1_col;
        out_word.port_word     = {1'b1, ~rd_pat, col_sel};

        n_col = r_col;
        if (scan_acc) begin
            n_col = (r_col == COL_LAST) ? '0 : r_col + COL_W'(1);
        end

        n_s1_vld = r_s1_vld && !s1_adv;
        n_s1_col = r_s1_col;
        if (scan_acc) begin
            n_s1_vld = 1'b1;
            n_s1_col = r_col;
        end

        n_out_vld  = r_out_vld && !i_m_axis_tready;
        n_out_data = r_out_data;
        if (r_s1_vld && s1_adv) begin
            n_out_vld  = 1'b1;
            n_out_data = out_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_col     <= n_col;
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_col   <= n_s1_col;
        r_out_data <= n_out_data;
    end

    assign o_s_axis_tready = in_rdy;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    // scan column never leaves the matrix
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_LAST)
        else $error("scan column out of range");

    // a scan tick advances the column with wrap
    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_acc |=> (r_col == (($past(r_col) == COL_LAST) ? '0 : $past(r_col) + COL_W'(1))))
        else $error("scan column did not advance");

    // a scan tick always loads the read stage
    a_s1_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_acc |=> r_s1_vld)
        else $error("scan tick lost before read stage");

    // a full pipe with a stalled output blocks new items
    a_stall_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_out_vld && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input taken while pipe is full");

    // a shown word selects exactly one column and keeps bit 15 high
    a_word_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ($onehot(~r_out_data.port_word[7:0]) && r_out_data.port_word[15]))
        else $error("malformed port word");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams scan ticks and column updates into the LED matrix scanner, predicts
// every port word from a private copy of the column patterns and scan column,
// and checks each output transfer in order against the predicted words.
// ----------------------------------------------------------------------------
module tb_top;
    import lmms_pkg::*;

    localparam int NUM_COLS   = DEF_NUM_COLUMNS;
    localparam int N_RANDOM   = 830;
    localparam int MAX_CYCLES = 200000;

    typedef struct {
        logic [ACT_W-1:0] action;
        logic [CH_W-1:0]  channel;
        logic [RAW_W-1:0] raw_bits;
        logic [LVL_W-1:0] meter_level;
        logic             switch_on;
        bit               drain_first;
    } t_cmd;

    typedef struct {
        logic [WORD_W-1:0] port_word;
        logic [COL_W-1:0]  column;
    } t_scan_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic [ACT_W-1:0]      i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    // pending commands, and port words predicted but not yet seen
    t_cmd       cmd_q[$];
    t_scan_word port_word_q[$];

    // predicted matrix state
    logic [ROW_W-1:0] col_rows [NUM_COLS];
    logic [COL_W-1:0] scan_col;

    t_cmd cur_cmd;
    int   n_cmds = 0;
    int   n_accepted = 0;
    int   n_errors = 0;
    int   n_cycles = 0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   rx_mode = 0;
    int   rx_left = 0;

    led_matrix_meter_scanner #(
        .NUM_COLUMNS(NUM_COLS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // meter row bits 6..1 for a level code
    function automatic logic [RAW_W-1:0] meter_rows(input logic [LVL_W-1:0] lvl);
        logic [RAW_W-1:0] bars;
        case (lvl)
            LVL_0DB:   bars = 6'b111111;
            LVL_M3DB:  bars = 6'b011111;
            LVL_M6DB:  bars = 6'b001111;
            LVL_M12DB: bars = 6'b000111;
            LVL_M18DB: bars = 6'b000011;
            LVL_M42DB: bars = 6'b000001;
            default:   bars = 6'b000000;
        endcase
        return bars;
    endfunction

    function automatic t_cmd mk_cmd(input logic [ACT_W-1:0] act, input int ch,
                                    input int raw, input logic [LVL_W-1:0] lvl,
                                    input bit sw);
        t_cmd c;
        c.action      = act;
        c.channel     = CH_W'(ch);
        c.raw_bits    = RAW_W'(raw);
        c.meter_level = lvl;
        c.switch_on   = sw;
        c.drain_first = 1'b0;
        return c;
    endfunction

    task automatic apply_matrix_cmd(input t_cmd c);
        t_scan_word w;
        logic [COL_W-1:0] idx;
        if (c.action == ACT_SCAN) begin
            w.column    = scan_col;
            w.port_word = {~{1'b0, col_rows[scan_col]}, ~(8'd1 << scan_col)};
            port_word_q.push_back(w);
            scan_col = (scan_col == COL_W'(NUM_COLS - 1)) ? '0 : scan_col + 1'b1;
        end else if (c.channel >= 1 && c.channel <= NUM_COLS) begin
            idx = COL_W'(c.channel - 1);
            case (c.action)
                ACT_RAW: begin
                    col_rows[idx][6:1] = c.raw_bits;
                end
                ACT_LEVEL: begin
                    if (c.meter_level != LVL_IGNORE)
                        col_rows[idx][6:1] = meter_rows(c.meter_level);
                end
                default: begin
                    col_rows[idx][0] = c.switch_on;
                end
            endcase
        end
    endtask

    task automatic flag_error(input string msg);
        n_errors++;
        if (n_errors <= 10)
            $display("[%0t] error: %s", $realtime, msg);
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge i_clk) begin : driver
        t_in_data d;
        logic     next_valid;
        if (!i_rst_n) begin
            foreach (col_rows[k])
                col_rows[k] = '0;
            scan_col = '0;
            i_s_axis_tvalid <= 1'b0;
        end else begin
            next_valid = i_s_axis_tvalid;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                apply_matrix_cmd(cur_cmd);
                n_accepted++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (cmd_q.size() != 0 &&
                             !(cmd_q[0].drain_first && port_word_q.size() != 0)) begin
                    cur_cmd       = cmd_q.pop_front();
                    d.pad         = '0;
                    d.switch_on   = cur_cmd.switch_on;
                    d.meter_level = cur_cmd.meter_level;
                    d.raw_bits    = cur_cmd.raw_bits;
                    d.channel     = cur_cmd.channel;
                    i_s_axis_tdata <= d;
                    i_s_axis_tuser <= cur_cmd.action;
                    next_valid = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            i_s_axis_tvalid <= next_valid;
        end
    end

    // receiver: checks each transfer, stalls in modes that change now and then
    always @(posedge i_clk) begin : monitor
        t_out_data  got;
        t_scan_word want;
        logic       rdy;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_out_data'(o_m_axis_tdata);
            if (port_word_q.size() == 0) begin
                flag_error($sformatf("unexpected word %h col %0d",
                                     got.port_word, got.column_index));
            end else begin
                want = port_word_q.pop_front();
                if (got.port_word !== want.port_word)
                    flag_error($sformatf("port_word exp %h got %h",
                                         want.port_word, got.port_word));
                if (got.column_index !== want.column)
                    flag_error($sformatf("column_index exp %0d got %0d",
                                         want.column, got.column_index));
            end
        end
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 120);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0:       rdy = 1'b1;
            1:       rdy = 1'($urandom_range(0, 1));
            2:       rdy = ($urandom_range(0, 3) == 0);
            default: rdy = (rx_left % 16 == 0);
        endcase
        i_m_axis_tready <= rdy;
    end

    always @(posedge i_clk) begin : watchdog
        n_cycles++;
        if (n_cycles > MAX_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_cmd c;
        int   r;

        // directed: dark scan, extremes, every level, switch on and off, bad channels
        cmd_q.push_back(mk_cmd(ACT_SCAN, 0, 0, LVL_OFF, 1'b0));
        cmd_q.push_back(mk_cmd(ACT_RAW, 1, 63, LVL_OFF, 1'b0));
        cmd_q.push_back(mk_cmd(ACT_RAW, NUM_COLS, 21, LVL_OFF, 1'b0));
        cmd_q.push_back(mk_cmd(ACT_RAW, 0, 63, LVL_OFF, 1'b0));
        cmd_q.push_back(mk_cmd(ACT_RAW, 15, 63, LVL_IGNORE, 1'b1));
        cmd_q.push_back(mk_cmd(ACT_LEVEL, 2, 0, LVL_0DB, 1'b0));
        cmd_q.push_back(mk_cmd(ACT_LEVEL, 3, 0, LVL_M3DB, 1'b0));
        cmd_q.push_back(mk_cmd(ACT_LEVEL, 4, 0, LVL_M6DB, 1'b0));
        cmd_q.push_back(mk_cmd(ACT_LEVEL, 5, 0, LVL_M12DB, 1'b0));
        cmd_q.push_back(mk_cmd(ACT_LEVEL, 6, 0, LVL_M18DB, 1'b0));
        cmd_q.push_back(mk_cmd(ACT_LEVEL, 7, 0, LVL_M42DB, 1'b0));
        cmd_q.push_back(mk_cmd(ACT_LEVEL, 2, 42, LVL_IGNORE, 1'b1));
        cmd_q.push_back(mk_cmd(ACT_LEVEL, NUM_COLS, 0, LVL_OFF, 1'b0));
        cmd_q.push_back(mk_cmd(ACT_SWITCH, 1, 0, LVL_OFF, 1'b1));
        cmd_q.push_back(mk_cmd(ACT_SWITCH, 3, 0, LVL_OFF, 1'b1));
        cmd_q.push_back(mk_cmd(ACT_SWITCH, 3, 0, LVL_OFF, 1'b0));
        cmd_q.push_back(mk_cmd(ACT_SWITCH, 9, 0, LVL_OFF, 1'b1));
        cmd_q.push_back(mk_cmd(ACT_LEVEL, 1, 0, LVL_OFF, 1'b0));
        for (int k = 0; k < NUM_COLS + 1; k++)
            cmd_q.push_back(mk_cmd(ACT_SCAN, 15, 63, LVL_IGNORE, 1'b1));

        // random: mostly valid channels, all fields random whatever the action
        for (int k = 0; k < N_RANDOM; k++) begin
            r = $urandom_range(0, 9);
            if (r < 4)
                c.action = ACT_SCAN;
            else if (r < 6)
                c.action = ACT_RAW;
            else if (r < 8)
                c.action = ACT_LEVEL;
            else
                c.action = ACT_SWITCH;
            if ($urandom_range(0, 9) == 0)
                c.channel = $urandom_range(0, 1) ? CH_W'(0)
                                                 : CH_W'($urandom_range(NUM_COLS + 1, 15));
            else
                c.channel = CH_W'($urandom_range(1, NUM_COLS));
            c.raw_bits    = RAW_W'($urandom_range(0, 63));
            c.meter_level = LVL_W'($urandom_range(0, 7));
            c.switch_on   = 1'($urandom_range(0, 1));
            c.drain_first = (k % 200 == 100) || ($urandom_range(0, 99) == 0);
            cmd_q.push_back(c);
        end
        n_cmds = cmd_q.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_cmds)
            @(posedge i_clk);
        while (port_word_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (n_errors == 0 && port_word_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/lmms_pkg.sv
hw/rtl/lmms_decode.sv
hw/rtl/lmms_store.sv
hw/rtl/led_matrix_meter_scanner.sv
dv/tb_top.sv
